[hdl/heap_timer_multiplexer_defines.svh]
// Assertion macros for the timer multiplexer
`ifndef HEAP_TIMER_MULTIPLEXER_DEFINES_SVH
`define HEAP_TIMER_MULTIPLEXER_DEFINES_SVH
`ifndef ASSERT_OFF
`define HTM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HTM_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HTM_ASSERT(label, clk, rst, prop, msg)
`define HTM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[hdl/htm_pkg.sv]
`default_nettype none
package htm_pkg;
  localparam int NumTimers = 16;
  localparam int IdW = 4;
  localparam int CntW = 5;
  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_STOP = 2'd1;
  localparam logic [1:0] OP_EXPIRE = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [1:0] KIND_EXPIRED = 2'd0;
  localparam logic [1:0] KIND_RELOAD = 2'd1;
  localparam logic [1:0] KIND_HWSTOP = 2'd2;
  localparam logic [0:0] REG_MIN_PERIOD = 1'd0;
  localparam logic [0:0] REG_EXPIRY_MARGIN = 1'd1;
  localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  timer_id;
    logic [31:0] ticks_from_now;
    logic [31:0] current_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  expired_id;
    logic [15:0] reload_ticks;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [0:0] index;
    logic [7:0] data;
  } cfg_item_t;

  function automatic logic precedes(input logic [31:0] base, input logic [31:0] a,
                                    input logic [31:0] b);
    logic [31:0] da;
    logic [31:0] db;
    da = a - base;
    db = b - base;
    return da < db;
  endfunction
endpackage
`default_nettype wire

[hdl/htm_if.sv]
`default_nettype none
interface htm_in_if;
  logic valid;
  logic ready;
  htm_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface htm_out_if;
  logic valid;
  logic ready;
  htm_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface htm_cfg_if;
  logic valid;
  logic ready;
  htm_pkg::cfg_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/heap_timer_multiplexer.sv]
// Timer multiplexer: one item (set, stop, expiry event) is taken at a time and
// yields up to seventeen results, ending with a reload or a hardware stop
// flagged by last; a none item or a stop of an unarmed timer yields none.
// The heap slots and match times live in two memories with registered reads,
// so every heap compare waits on two reads in sequence. A stop or re-arm
// first scans the heap slot by slot for the timer. Each result waits while
// out_ch holds ready low. Configuration writes apply at once.
`default_nettype none
`include "heap_timer_multiplexer_defines.svh"
module heap_timer_multiplexer (
  input  wire logic clk,
  input  wire logic rst,
  htm_in_if.sink    in_ch,
  htm_out_if.source out_ch,
  htm_cfg_if.sink   cfg
);
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_FIND   = 5'd1;
  localparam logic [4:0] S_FINDW  = 5'd2;
  localparam logic [4:0] S_RMLAST = 5'd3;
  localparam logic [4:0] S_RMLW   = 5'd4;
  localparam logic [4:0] S_RMT    = 5'd5;
  localparam logic [4:0] S_RMP    = 5'd6;
  localparam logic [4:0] S_RMPT   = 5'd7;
  localparam logic [4:0] S_UPA    = 5'd8;
  localparam logic [4:0] S_UPB    = 5'd9;
  localparam logic [4:0] S_UPC    = 5'd10;
  localparam logic [4:0] S_DNA    = 5'd11;
  localparam logic [4:0] S_DNB    = 5'd12;
  localparam logic [4:0] S_DNC    = 5'd13;
  localparam logic [4:0] S_DND    = 5'd14;
  localparam logic [4:0] S_INS    = 5'd15;
  localparam logic [4:0] S_EXA    = 5'd16;
  localparam logic [4:0] S_EXB    = 5'd17;
  localparam logic [4:0] S_EXC    = 5'd18;
  localparam logic [4:0] S_FIN    = 5'd19;
  localparam logic [4:0] S_OUT    = 5'd20;
  localparam logic [4:0] S_FINA   = 5'd21;
  localparam logic [4:0] S_FINB   = 5'd22;
  localparam logic [4:0] S_FINC   = 5'd23;

  logic [3:0]  heap_mem [htm_pkg::NumTimers];
  logic [31:0] time_mem [htm_pkg::NumTimers];
  logic [htm_pkg::NumTimers-1:0] armed;
  logic [4:0] count;
  logic [7:0] min_period;
  logic [3:0] margin;

  logic [4:0] state;
  logic [4:0] after_out;
  logic       pass2;
  logic [1:0] op;
  logic [3:0] id;
  logic [31:0] now;
  logic [31:0] ticks;
  logic [3:0] n;
  logic [3:0] c;
  logic [3:0] id_n;
  logic [3:0] id_c;
  logic [3:0] id_c2;
  logic [31:0] t_n;
  logic [31:0] t_c;
  logic [3:0] hrd;
  logic [31:0] trd;
  logic out_valid;
  htm_pkg::out_item_t out_data;

  logic [31:0] base;
  logic [31:0] lim_d;
  logic [31:0] m_d;
  logic [31:0] dlt;
  logic [4:0]  cw;
  assign base = now + htm_pkg::HALF_RANGE;
  assign lim_d = now + {28'd0, margin} - base;
  assign m_d = trd - base;
  assign dlt = trd - now;
  assign cw = ({1'b0, n} + 5'd1) << 1;

  logic        dn_left;
  logic [31:0] dn_t;
  logic        dn_swap;
  assign dn_left = (cw == count) || htm_pkg::precedes(base, t_c, trd);
  assign dn_t = (cw == count || !dn_left) ? trd : t_c;
  assign dn_swap = htm_pkg::precedes(base, dn_t, t_n);

  logic        hwe;
  logic [3:0]  hwa;
  logic [3:0]  hwd;
  logic [3:0]  hra;
  logic        twe;
  logic [3:0]  twa;
  logic [31:0] twd;
  logic [3:0]  tra;

  always_ff @(posedge clk) begin
    if (hwe) heap_mem[hwa] <= hwd;
    hrd <= heap_mem[hra];
  end
  always_ff @(posedge clk) begin
    if (twe) time_mem[twa] <= twd;
    trd <= time_mem[tra];
  end

  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;

  always_comb begin
    hwe = 1'b0;
    hwa = n;
    hwd = id_n;
    hra = n;
    twe = 1'b0;
    twa = id;
    twd = now + ticks;
    tra = id_n;
    unique case (state)
      S_FIND: hra = n;
      S_RMLAST: hra = count[3:0];
      S_RMLW: begin
        hwe = 1'b1;
        hwa = n;
        hwd = hrd;
        tra = hrd;
      end
      S_RMT: hra = 4'((n - 4'd1) >> 1);
      S_RMP: tra = hrd;
      S_UPA: begin
        hra = 4'((n - 4'd1) >> 1);
        hwe = 1'b1;
        hwa = n;
        hwd = id_n;
      end
      S_UPB: tra = hrd;
      S_UPC: begin
        if (htm_pkg::precedes(base, t_n, trd)) begin
          hwe = 1'b1;
          hwa = n;
          hwd = id_c;
        end
      end
      S_DNA: begin
        hra = 4'(cw - 5'd1);
        hwe = 1'b1;
        hwa = n;
        hwd = id_n;
      end
      S_DNB: begin
        hra = cw[3:0];
        tra = hrd;
      end
      S_DNC: tra = hrd;
      S_DND: begin
        if (dn_swap) begin
          hwe = 1'b1;
          hwa = n;
          hwd = dn_left ? id_c : id_c2;
        end
      end
      S_INS: begin
        twe = 1'b1;
        hwe = 1'b1;
        hwa = count[3:0];
        hwd = id;
      end
      S_EXA: hra = 4'd0;
      S_EXB: begin
        hra = 4'd0;
        tra = hrd;
      end
      S_FINA: hra = 4'd0;
      S_FINB: tra = hrd;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      armed <= '0;
      count <= '0;
      min_period <= 8'd5;
      margin <= 4'd3;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.data.index)
          htm_pkg::REG_MIN_PERIOD: min_period <= cfg.data.data;
          htm_pkg::REG_EXPIRY_MARGIN: margin <= cfg.data.data[3:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            op <= in_ch.data.opcode;
            id <= in_ch.data.timer_id;
            now <= in_ch.data.current_count;
            ticks <= (in_ch.data.ticks_from_now < {24'd0, min_period})
                     ? {24'd0, min_period} : in_ch.data.ticks_from_now;
            n <= 4'd0;
            pass2 <= 1'b0;
            if (in_ch.data.opcode == htm_pkg::OP_EXPIRE) begin
              state <= S_EXA;
            end else if (in_ch.data.opcode == htm_pkg::OP_SET) begin
              state <= armed[in_ch.data.timer_id] ? S_FIND : S_INS;
            end else if (in_ch.data.opcode == htm_pkg::OP_STOP
                         && armed[in_ch.data.timer_id]) begin
              state <= S_FIND;
            end
          end
        end
        S_FIND: state <= S_FINDW;
        S_FINDW: begin
          if (hrd == id) begin
            armed[id] <= 1'b0;
            count <= count - 5'd1;
            state <= S_RMLAST;
          end else begin
            n <= n + 4'd1;
            state <= S_FIND;
          end
        end
        S_RMLAST: begin
          if ({1'b0, n} == count) state <= S_EXA;
          else state <= S_RMLW;
        end
        S_RMLW: begin
          id_n <= hrd;
          state <= S_RMT;
        end
        S_RMT: begin
          t_n <= trd;
          state <= (n == 4'd0) ? S_DNA : S_RMP;
        end
        S_RMP: state <= S_RMPT;
        S_RMPT: begin
          state <= htm_pkg::precedes(base, t_n, trd) ? S_UPA : S_DNA;
        end
        S_INS: begin
          count <= count + 5'd1;
          armed[id] <= 1'b1;
          n <= count[3:0];
          id_n <= id;
          t_n <= now + ticks;
          pass2 <= 1'b1;
          state <= S_UPA;
        end
        S_UPA: state <= (n == 4'd0) ? S_EXA : S_UPB;
        S_UPB: begin
          id_c <= hrd;
          state <= S_UPC;
        end
        S_UPC: begin
          if (htm_pkg::precedes(base, t_n, trd)) begin
            n <= 4'((n - 4'd1) >> 1);
            state <= S_UPA;
          end else begin
            state <= S_EXA;
          end
        end
        S_DNA: begin
          c <= 4'(cw - 5'd1);
          state <= (cw > count) ? S_EXA : S_DNB;
        end
        S_DNB: begin
          id_c <= hrd;
          state <= (cw == count) ? S_DND : S_DNC;
        end
        S_DNC: begin
          t_c <= trd;
          id_c2 <= hrd;
          state <= S_DND;
        end
        S_DND: begin
          if (dn_swap) begin
            n <= dn_left ? c : cw[3:0];
            state <= S_DNA;
          end else begin
            state <= S_EXA;
          end
        end
        S_EXA: begin
          state <= (count == 5'd0) ? S_FIN : S_EXB;
        end
        S_EXB: state <= S_EXC;
        S_EXC: begin
          if (m_d <= lim_d) begin
            armed[hrd] <= 1'b0;
            count <= count - 5'd1;
            out_data <= '{kind: htm_pkg::KIND_EXPIRED, expired_id: hrd,
                          reload_ticks: 16'd0, last: 1'b0};
            out_valid <= 1'b1;
            n <= 4'd0;
            after_out <= S_RMLAST;
            state <= S_OUT;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (op == htm_pkg::OP_SET && !pass2) begin
            state <= (count == 5'(htm_pkg::NumTimers)) ? S_IDLE : S_INS;
          end else if (count == 5'd0) begin
            out_data <= '{kind: htm_pkg::KIND_HWSTOP, expired_id: 4'd0,
                          reload_ticks: 16'd0, last: 1'b1};
            out_valid <= 1'b1;
            after_out <= S_IDLE;
            state <= S_OUT;
          end else begin
            state <= S_FINA;
          end
        end
        S_FINA: state <= S_FINB;
        S_FINB: state <= S_FINC;
        S_FINC: begin
          out_data <= '{kind: htm_pkg::KIND_RELOAD, expired_id: 4'd0,
                        reload_ticks: (dlt > 32'hFFFF) ? 16'hFFF0 : dlt[15:0],
                        last: 1'b1};
          out_valid <= 1'b1;
          after_out <= S_IDLE;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_valid <= 1'b0;
            state <= after_out;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `HTM_ASSERT(a_out_idle, clk, rst, out_valid |-> state == S_OUT, "result outside output state")
  `HTM_ASSERT(a_count, clk, rst, count <= 5'(htm_pkg::NumTimers), "heap count overflow")
  `HTM_ASSERT(a_ready, clk, rst, in_ch.ready |-> !out_valid, "input taken with result pending")
endmodule
`default_nettype wire
